>>> sv/onewire_bus_master_core_macros.svh
// Assertion helpers used by the engine design file.
`ifndef ONEWIRE_BUS_MASTER_CORE_MACROS_SVH
`define ONEWIRE_BUS_MASTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OBM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("onewire bus master: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define OBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("onewire bus master: next-cycle check failed");

`endif

>>> sv/obm_pkg.sv
package obm_pkg;

   // Configuration register file geometry.
   localparam int unsigned CFG_WIDTH  = 12;
   localparam int unsigned ADDR_WIDTH = 5;
   localparam int unsigned DATA_WIDTH = 32;

   typedef logic [CFG_WIDTH-1:0] cfg_word_type;

   // Register indexes, as found in paddr[4:2].
   localparam logic [2:0] REG_RESET_LOW      = 3'd0;
   localparam logic [2:0] REG_PRESENCE_WAIT  = 3'd1;
   localparam logic [2:0] REG_RESET_RECOVERY = 3'd2;
   localparam logic [2:0] REG_WR1_LOW        = 3'd3;
   localparam logic [2:0] REG_WR1_RELEASE    = 3'd4;
   localparam logic [2:0] REG_WR0_LOW        = 3'd5;
   localparam logic [2:0] REG_WR0_RELEASE    = 3'd6;
   localparam logic [2:0] REG_READ_RECOVERY  = 3'd7;

   // Command codes of a command transaction.
   localparam logic [1:0] CMD_RESET      = 2'd0;
   localparam logic [1:0] CMD_WRITE_BYTE = 2'd1;
   localparam logic [1:0] CMD_READ_BYTE  = 2'd2;
   localparam logic [1:0] CMD_READ_BIT   = 2'd3;

   // Reset values of the timing registers.
   localparam cfg_word_type RESET_LOW_DEFAULT      = 12'd500;
   localparam cfg_word_type PRESENCE_WAIT_DEFAULT  = 12'd80;
   localparam cfg_word_type RESET_RECOVERY_DEFAULT = 12'd410;
   localparam cfg_word_type WR1_LOW_DEFAULT        = 12'd10;
   localparam cfg_word_type WR1_RELEASE_DEFAULT    = 12'd55;
   localparam cfg_word_type WR0_LOW_DEFAULT        = 12'd65;
   localparam cfg_word_type WR0_RELEASE_DEFAULT    = 12'd5;
   localparam cfg_word_type READ_RECOVERY_DEFAULT  = 12'd50;

   // Fixed waits of the read slot.
   localparam cfg_word_type RD_LOW_TICKS    = 12'd2;
   localparam cfg_word_type RD_SAMPLE_TICKS = 12'd10;

   typedef struct packed {
      cfg_word_type reset_low_us;
      cfg_word_type presence_wait_us;
      cfg_word_type reset_recovery_us;
      cfg_word_type write_one_low_us;
      cfg_word_type write_one_release_us;
      cfg_word_type write_zero_low_us;
      cfg_word_type write_zero_release_us;
      cfg_word_type read_recovery_us;
   } cfg_type;

   // One input transaction.
   typedef struct packed {
      logic       req_type;
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       line_level;
   } item_type;

   // One result transaction.
   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] read_data;
      logic       rejected;
   } result_type;

endpackage

>>> sv/obm_csr.sv
module obm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [obm_pkg::ADDR_WIDTH-1:0]       paddr,
   input  logic [obm_pkg::DATA_WIDTH-1:0]       pwdata,
   output logic [obm_pkg::DATA_WIDTH-1:0]       prdata,
   output logic                                 pready,
   output obm_pkg::cfg_type                     cfg
);

   obm_pkg::cfg_type     cfg_ff;
   obm_pkg::cfg_type     cfg_in;
   logic [2:0]           reg_index;
   logic                 wr_en;
   obm_pkg::cfg_word_type wr_word;
   obm_pkg::cfg_word_type rd_word;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign wr_en     = psel & penable & pwrite & pready;
   assign wr_word   = pwdata[obm_pkg::CFG_WIDTH-1:0];

   // Write decode: the addressed register takes the low bits of the data.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            obm_pkg::REG_RESET_LOW:      cfg_in.reset_low_us          = wr_word;
            obm_pkg::REG_PRESENCE_WAIT:  cfg_in.presence_wait_us      = wr_word;
            obm_pkg::REG_RESET_RECOVERY: cfg_in.reset_recovery_us     = wr_word;
            obm_pkg::REG_WR1_LOW:        cfg_in.write_one_low_us      = wr_word;
            obm_pkg::REG_WR1_RELEASE:    cfg_in.write_one_release_us  = wr_word;
            obm_pkg::REG_WR0_LOW:        cfg_in.write_zero_low_us     = wr_word;
            obm_pkg::REG_WR0_RELEASE:    cfg_in.write_zero_release_us = wr_word;
            obm_pkg::REG_READ_RECOVERY:  cfg_in.read_recovery_us      = wr_word;
         endcase
      end
   end

   // Registers come out of reset with the standard slot timings.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_us          <= obm_pkg::RESET_LOW_DEFAULT;
         cfg_ff.presence_wait_us      <= obm_pkg::PRESENCE_WAIT_DEFAULT;
         cfg_ff.reset_recovery_us     <= obm_pkg::RESET_RECOVERY_DEFAULT;
         cfg_ff.write_one_low_us      <= obm_pkg::WR1_LOW_DEFAULT;
         cfg_ff.write_one_release_us  <= obm_pkg::WR1_RELEASE_DEFAULT;
         cfg_ff.write_zero_low_us     <= obm_pkg::WR0_LOW_DEFAULT;
         cfg_ff.write_zero_release_us <= obm_pkg::WR0_RELEASE_DEFAULT;
         cfg_ff.read_recovery_us      <= obm_pkg::READ_RECOVERY_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_index)
         obm_pkg::REG_RESET_LOW:      rd_word = cfg_ff.reset_low_us;
         obm_pkg::REG_PRESENCE_WAIT:  rd_word = cfg_ff.presence_wait_us;
         obm_pkg::REG_RESET_RECOVERY: rd_word = cfg_ff.reset_recovery_us;
         obm_pkg::REG_WR1_LOW:        rd_word = cfg_ff.write_one_low_us;
         obm_pkg::REG_WR1_RELEASE:    rd_word = cfg_ff.write_one_release_us;
         obm_pkg::REG_WR0_LOW:        rd_word = cfg_ff.write_zero_low_us;
         obm_pkg::REG_WR0_RELEASE:    rd_word = cfg_ff.write_zero_release_us;
         obm_pkg::REG_READ_RECOVERY:  rd_word = cfg_ff.read_recovery_us;
      endcase
   end

   assign prdata = obm_pkg::DATA_WIDTH'(rd_word);
   assign cfg    = cfg_ff;

endmodule

>>> sv/obm_engine.sv
`include "onewire_bus_master_core_macros.svh"

module obm_engine #(
   parameter int unsigned TIMER_BITS        = 12,
   parameter int unsigned BITS_PER_TRANSFER = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  obm_pkg::item_type    item,
   input  obm_pkg::cfg_type     cfg,
   output obm_pkg::result_type  result
);

   // Slot sequencer phases.
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RST_LOW  = 4'd1;
   localparam logic [3:0] PH_RST_WAIT = 4'd2;
   localparam logic [3:0] PH_RST_REC  = 4'd3;
   localparam logic [3:0] PH_WR_LOW   = 4'd4;
   localparam logic [3:0] PH_WR_REL   = 4'd5;
   localparam logic [3:0] PH_RD_LOW   = 4'd6;
   localparam logic [3:0] PH_RD_WAIT  = 4'd7;
   localparam logic [3:0] PH_RD_REC   = 4'd8;

   localparam logic [3:0] BITS_LOAD = 4'(BITS_PER_TRANSFER);

   logic [3:0]            phase_ff,  phase_in;
   logic [TIMER_BITS-1:0] timer_ff,  timer_in;
   logic [7:0]            shift_ff,  shift_in;
   logic [3:0]            bits_ff,   bits_in;
   logic [1:0]            cmd_ff,    cmd_in;
   logic                  pres_ff,   pres_in;
   logic                  done;
   logic                  rej;
   logic                  bit_end;
   logic [3:0]            bits_dec;

   assign bits_dec = bits_ff - 4'd1;

   // Next state for the transaction in the input register.
   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      cmd_in   = cmd_ff;
      pres_in  = pres_ff;
      done     = 1'b0;
      rej      = 1'b0;
      bit_end  = 1'b0;
      if (item.req_type) begin
         // A new command is only taken while the bus is idle.
         if (phase_ff != PH_IDLE) begin
            rej = 1'b1;
         end else begin
            cmd_in = item.command;
            if (item.command == obm_pkg::CMD_RESET) begin
               pres_in  = 1'b0;
               phase_in = PH_RST_LOW;
               timer_in = TIMER_BITS'(cfg.reset_low_us);
            end else if (item.command == obm_pkg::CMD_WRITE_BYTE) begin
               shift_in = item.data_byte;
               bits_in  = BITS_LOAD;
               phase_in = PH_WR_LOW;
               timer_in = item.data_byte[0] ? TIMER_BITS'(cfg.write_one_low_us)
                                            : TIMER_BITS'(cfg.write_zero_low_us);
            end else begin
               shift_in = 8'd0;
               bits_in  = (item.command == obm_pkg::CMD_READ_BIT) ? 4'd1 : BITS_LOAD;
               phase_in = PH_RD_LOW;
               timer_in = TIMER_BITS'(obm_pkg::RD_LOW_TICKS);
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         // A tick: count down, or move on when the wait has run out.
         if (timer_ff != '0) begin
            timer_in = timer_ff - 1'b1;
         end else begin
            unique case (phase_ff)
               PH_RST_LOW: begin
                  phase_in = PH_RST_WAIT;
                  timer_in = TIMER_BITS'(cfg.presence_wait_us);
               end
               PH_RST_WAIT: begin
                  pres_in  = ~item.line_level;
                  phase_in = PH_RST_REC;
                  timer_in = TIMER_BITS'(cfg.reset_recovery_us);
               end
               PH_WR_LOW: begin
                  phase_in = PH_WR_REL;
                  timer_in = shift_ff[0] ? TIMER_BITS'(cfg.write_one_release_us)
                                         : TIMER_BITS'(cfg.write_zero_release_us);
               end
               PH_WR_REL: begin
                  shift_in = {1'b0, shift_ff[7:1]};
                  bit_end  = 1'b1;
               end
               PH_RD_LOW: begin
                  phase_in = PH_RD_WAIT;
                  timer_in = TIMER_BITS'(obm_pkg::RD_SAMPLE_TICKS);
               end
               PH_RD_WAIT: begin
                  shift_in = (cmd_ff == obm_pkg::CMD_READ_BIT) ? {7'd0, item.line_level}
                                                               : {item.line_level, shift_ff[7:1]};
                  phase_in = PH_RD_REC;
                  timer_in = TIMER_BITS'(cfg.read_recovery_us);
               end
               PH_RD_REC: begin
                  bit_end = 1'b1;
               end
               default: begin
                  // Reset recovery over, or a phase code with no meaning.
                  phase_in = PH_IDLE;
                  timer_in = '0;
                  done     = 1'b1;
               end
            endcase
            // End of a bit slot: start the next bit or finish.
            if (bit_end) begin
               bits_in = bits_dec;
               if (bits_dec != 4'd0) begin
                  if (cmd_ff == obm_pkg::CMD_WRITE_BYTE) begin
                     phase_in = PH_WR_LOW;
                     timer_in = shift_in[0] ? TIMER_BITS'(cfg.write_one_low_us)
                                            : TIMER_BITS'(cfg.write_zero_low_us);
                  end else begin
                     phase_in = PH_RD_LOW;
                     timer_in = TIMER_BITS'(obm_pkg::RD_LOW_TICKS);
                  end
               end else begin
                  phase_in = PH_IDLE;
                  timer_in = '0;
                  done     = 1'b1;
               end
            end
         end
      end
   end

   // Result fields follow the state left by this transaction.
   always_comb begin
      result.drive_low = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW) ||
                         (phase_in == PH_RD_LOW);
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.presence  = done && (cmd_ff == obm_pkg::CMD_RESET) && pres_in;
      result.read_data = (done && ((cmd_ff == obm_pkg::CMD_READ_BYTE) ||
                                   (cmd_ff == obm_pkg::CMD_READ_BIT)))
                         ? shift_in : 8'd0;
      result.rejected  = rej;
   end

   // Sequencer state advances once per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         shift_ff <= 8'd0;
         bits_ff  <= 4'd0;
         cmd_ff   <= obm_pkg::CMD_RESET;
         pres_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         cmd_ff   <= cmd_in;
         pres_ff  <= pres_in;
      end
   end

   // A finished command always leaves the sequencer idle.
   `OBM_ASSERT_NOW(a_done_idle, clock, reset, result.done_res, !result.busy_res)
   // Presence is reported only at the end of a bus reset.
   `OBM_ASSERT_NOW(a_pres_reset, clock, reset, result.presence,
                   result.done_res && (cmd_ff == obm_pkg::CMD_RESET))
   // Without a transaction the sequencer does not move.
   `OBM_ASSERT_NEXT(a_hold, clock, reset, !step,
                    $stable(phase_ff) && $stable(timer_ff) && $stable(bits_ff))
   // A running count keeps the phase until it reaches zero.
   `OBM_ASSERT_NEXT(a_count, clock, reset,
                    step && !item.req_type && (phase_ff != PH_IDLE) && (timer_ff != '0),
                    phase_ff == $past(phase_ff))

endmodule

>>> sv/onewire_bus_master_core.sv
// Channel   | Direction | Handshake            | Payload
// req_*     | in        | req_valid/req_ready  | req_type, command, data_byte, line_level
// rsp_*     | out       | rsp_valid/rsp_ready  | drive_low, busy_res, done_res, presence,
//           |           |                      | read_data, rejected
// APB       | in/out    | psel/penable, pready | paddr, pwdata, prdata
//
// One transaction is accepted per cycle while rsp_ready is high; its result is
// offered once the sequencer update has passed from the input register into the
// result register.
// Reset is synchronous and active high; it empties both registers, idles the
// sequencer and restores the default slot timings.
// When a result is waiting and rsp_ready is low the result register holds, and
// req_ready falls once the input register is also full. APB writes complete in the access cycle.
module onewire_bus_master_core #(
   parameter int unsigned TIMER_BITS        = 12,
   parameter int unsigned BITS_PER_TRANSFER = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_type,
   input  logic [1:0]                     req_command,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_line_level,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_drive_low,
   output logic                           rsp_busy_res,
   output logic                           rsp_done_res,
   output logic                           rsp_presence,
   output logic [7:0]                     rsp_read_data,
   output logic                           rsp_rejected,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [obm_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [obm_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [obm_pkg::DATA_WIDTH-1:0] prdata,
   output logic                           pready
);

   obm_pkg::cfg_type    cfg;
   obm_pkg::item_type   in_item_ff;
   logic                in_valid_ff;
   obm_pkg::result_type res;
   obm_pkg::result_type out_res_ff;
   logic                out_valid_ff;
   logic                step;
   logic                req_fire;

   obm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The held transaction moves on when the result register can take it.
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_fire  = req_valid && req_ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.req_type   <= req_type;
         in_item_ff.command    <= req_command;
         in_item_ff.data_byte  <= req_data_byte;
         in_item_ff.line_level <= req_line_level;
      end
   end

   obm_engine #(
      .TIMER_BITS        (TIMER_BITS),
      .BITS_PER_TRANSFER (BITS_PER_TRANSFER)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (res)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_res_ff <= res;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_drive_low = out_res_ff.drive_low;
   assign rsp_busy_res  = out_res_ff.busy_res;
   assign rsp_done_res  = out_res_ff.done_res;
   assign rsp_presence  = out_res_ff.presence;
   assign rsp_read_data = out_res_ff.read_data;
   assign rsp_rejected  = out_res_ff.rejected;

endmodule
